[sv/tmda_pkg.sv]
// Package for the tetrahedron minimum dihedral angle core.
// Holds the payload structs, the edge table, the arctangent table and the fixed widths.
// No dependencies.
package tmda_pkg;

   localparam int CoordW   = 16;
   localparam int AngleW   = 18;
   localparam int FracZ    = 60;
   localparam int Steps    = 40;
   localparam int NormW    = 31;   // signed normalized normal component
   localparam int ZW       = 64;

   typedef struct packed {
      logic signed [CoordW-1:0] v0_x;
      logic signed [CoordW-1:0] v0_y;
      logic signed [CoordW-1:0] v0_z;
      logic signed [CoordW-1:0] v1_x;
      logic signed [CoordW-1:0] v1_y;
      logic signed [CoordW-1:0] v1_z;
      logic signed [CoordW-1:0] v2_x;
      logic signed [CoordW-1:0] v2_y;
      logic signed [CoordW-1:0] v2_z;
      logic signed [CoordW-1:0] v3_x;
      logic signed [CoordW-1:0] v3_y;
      logic signed [CoordW-1:0] v3_z;
   } req_type;

   typedef struct packed {
      logic [AngleW-1:0] min_angle;
      logic              degenerate;
   } rsp_type;

   // Edge list: the edge's two vertices, then the two off-edge vertices.
   typedef logic [1:0] vidx_type;
   typedef vidx_type [3:0] edge_type;
   localparam edge_type EdgeTab [6] = '{
      '{2'd3, 2'd2, 2'd1, 2'd0}, '{2'd3, 2'd1, 2'd2, 2'd0},
      '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd3, 2'd0, 2'd2, 2'd1},
      '{2'd2, 2'd0, 2'd3, 2'd1}, '{2'd1, 2'd0, 2'd3, 2'd2}
   };

   // Unsigned long division, used only while the constant tables are built.
   function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q, r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         if (r >= b) begin
            r = r - b;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(1/n) with 60 fraction bits, from the truncated series.
   function automatic logic [63:0] atan_inv(input logic [63:0] n);
      logic [63:0] p, sum, k, term;
      p = udiv(64'd1 << FracZ, n);
      sum = '0;
      k = '0;
      while (p != 0) begin
         term = udiv(p, 2 * k + 1);
         if (k[0]) sum = sum - term;
         else sum = sum + term;
         p = udiv(p, n * n);
         k = k + 1;
      end
      return sum;
   endfunction

   function automatic logic [63:0] atan_tab(input int i);
      logic [63:0] sum, k, term;
      int e;
      sum = '0;
      k = '0;
      if (i == 0) return 64'd4 * atan_inv(64'd5) - atan_inv(64'd239);
      while (64'(i) * (2 * k + 1) <= 64'(FracZ)) begin
         e = FracZ - i * int'(2 * k + 1);
         term = udiv(64'd1 << e, 2 * k + 1);
         if (k[0]) sum = sum - term;
         else sum = sum + term;
         k = k + 1;
      end
      return sum;
   endfunction

   localparam logic [63:0] PiZ = 64'd4 * (64'd4 * atan_inv(64'd5) - atan_inv(64'd239));

endpackage

[sv/tmda_normal.sv]
// Per-edge front end: edge vectors, two face normals, normalization, dot and cross.
// Depends on tmda_pkg. Pipeline with valid bits; four register stages.
module tmda_normal #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [COORD_BITS-1:0]  vi [3],
   input  logic signed [COORD_BITS-1:0]  vj [3],
   input  logic signed [COORD_BITS-1:0]  vk [3],
   input  logic signed [COORD_BITS-1:0]  vm [3],
   output logic                          out_valid,
   output logic                          out_zero,
   output logic signed [63:0]            out_c,
   output logic signed [63:0]            out_w [3]
);
   import tmda_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW + 1;

   logic signed [DW-1:0] ev_in [3], ak_in [3], am_in [3];
   logic signed [DW-1:0] ev_ff [3], ak_ff [3], am_ff [3];
   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [PW-1:0] n1_in [3], n2_in [3], n1_ff [3], n2_ff [3];
   logic signed [NormW-1:0] s1_in [3], s2_in [3], s1_ff [3], s2_ff [3];
   logic                 z_in, z2_ff, z3_ff;
   logic signed [63:0]   p_in [9], p_ff [9];

   function automatic logic [PW-1:0] mag_f(input logic signed [PW-1:0] v);
      return v[PW-1] ? PW'(-v) : PW'(v);
   endfunction

   // Scale largest magnitude into [2^29, 2^30); truncate toward zero.
   function automatic void norm_f(input logic signed [PW-1:0] n [3],
                                  output logic signed [NormW-1:0] r [3]);
      logic [PW-1:0] m, a;
      logic [PW+30:0] t;
      int hb, sh;
      m = '0;
      hb = 0;
      for (int i = 0; i < 3; i++) if (mag_f(n[i]) > m) m = mag_f(n[i]);
      for (int b = 0; b < PW; b++) if (m[b]) hb = b;
      sh = hb - 29;
      for (int i = 0; i < 3; i++) begin
         a = mag_f(n[i]);
         if (sh >= 0) t = (PW+31)'(a) >> sh;
         else t = (PW+31)'(a) << (-sh);
         r[i] = n[i][PW-1] ? -NormW'(t) : NormW'(t);
      end
   endfunction

   always_comb begin
      for (int b = 0; b < 3; b++) begin
         ev_in[b] = DW'(vj[b]) - DW'(vi[b]);
         ak_in[b] = DW'(vk[b]) - DW'(vi[b]);
         am_in[b] = DW'(vm[b]) - DW'(vi[b]);
      end
      n1_in[0] = PW'(ev_ff[1]) * PW'(ak_ff[2]) - PW'(ev_ff[2]) * PW'(ak_ff[1]);
      n1_in[1] = PW'(ev_ff[2]) * PW'(ak_ff[0]) - PW'(ev_ff[0]) * PW'(ak_ff[2]);
      n1_in[2] = PW'(ev_ff[0]) * PW'(ak_ff[1]) - PW'(ev_ff[1]) * PW'(ak_ff[0]);
      n2_in[0] = PW'(ev_ff[1]) * PW'(am_ff[2]) - PW'(ev_ff[2]) * PW'(am_ff[1]);
      n2_in[1] = PW'(ev_ff[2]) * PW'(am_ff[0]) - PW'(ev_ff[0]) * PW'(am_ff[2]);
      n2_in[2] = PW'(ev_ff[0]) * PW'(am_ff[1]) - PW'(ev_ff[1]) * PW'(am_ff[0]);
      z_in = (n1_ff[0] == 0 && n1_ff[1] == 0 && n1_ff[2] == 0) ||
             (n2_ff[0] == 0 && n2_ff[1] == 0 && n2_ff[2] == 0);
      norm_f(n1_ff, s1_in);
      norm_f(n2_ff, s2_in);
      // Nine partial products; sums are formed combinationally after the product register.
      p_in[0] = 64'(s1_ff[0]) * 64'(s2_ff[0]);
      p_in[1] = 64'(s1_ff[1]) * 64'(s2_ff[1]);
      p_in[2] = 64'(s1_ff[2]) * 64'(s2_ff[2]);
      p_in[3] = 64'(s1_ff[1]) * 64'(s2_ff[2]);
      p_in[4] = 64'(s1_ff[2]) * 64'(s2_ff[1]);
      p_in[5] = 64'(s1_ff[2]) * 64'(s2_ff[0]);
      p_in[6] = 64'(s1_ff[0]) * 64'(s2_ff[2]);
      p_in[7] = 64'(s1_ff[0]) * 64'(s2_ff[1]);
      p_in[8] = 64'(s1_ff[1]) * 64'(s2_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      ev_ff <= ev_in;
      ak_ff <= ak_in;
      am_ff <= am_in;
      n1_ff <= n1_in;
      n2_ff <= n2_in;
      z2_ff <= z_in;
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      z3_ff <= z2_ff;
      p_ff  <= p_in;
   end

   assign out_valid = v4_ff;
   assign out_zero  = z3_ff;
   assign out_c     = p_ff[0] + p_ff[1] + p_ff[2];
   assign out_w[0]  = p_ff[3] - p_ff[4];
   assign out_w[1]  = p_ff[5] - p_ff[6];
   assign out_w[2]  = p_ff[7] - p_ff[8];
endmodule

[sv/tmda_angle.sv]
// Per-edge back end: length of the cross product, prescale, pipelined CORDIC, fold.
// Depends on tmda_pkg. Square root is one result bit per stage.
module tmda_angle (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_zero,
   input  logic signed [63:0] in_c,
   input  logic signed [63:0] in_w [3],
   output logic               out_valid,
   output logic               out_zero,
   output logic [63:0]        out_ang
);
   import tmda_pkg::*;

   localparam int SqStages = 32;
   localparam int NegLen = SqStages + 1 + Steps;
   localparam int Lat = 3 + NegLen + 1;

   // Stage A: register dot and cross; stage B: shift t; stage C: squares sum.
   logic signed [63:0] c_a_ff;
   logic [63:0]        wm_a_ff [3];
   logic [5:0]         t_in;
   logic [31:0]        q_b_ff [3];
   logic signed [63:0] c_b_ff;
   logic               neg_c_ff;
   logic [Lat-1:0]     val_ff, zero_ff;
   logic [NegLen-1:0]  neg_ff;
   logic [63:0]        sq_n_ff [SqStages+1];
   logic [63:0]        sq_r_ff [SqStages+1];
   logic [63:0]        sq_x_ff [SqStages+1];

   always_comb begin
      t_in = '0;
      for (int s = 0; s < 34; s++)
         if ((wm_a_ff[0] >> s) >= 64'h8000_0000 || (wm_a_ff[1] >> s) >= 64'h8000_0000 ||
             (wm_a_ff[2] >> s) >= 64'h8000_0000)
            t_in = 6'(s + 1);
   end

   always_ff @(posedge clock) begin
      c_a_ff <= in_c;
      for (int i = 0; i < 3; i++)
         wm_a_ff[i] <= in_w[i][63] ? 64'(-in_w[i]) : 64'(in_w[i]);
      for (int i = 0; i < 3; i++) q_b_ff[i] <= 32'(wm_a_ff[i] >> t_in);
      c_b_ff <= c_a_ff[63] ? -64'((-c_a_ff) >> t_in) : 64'(c_a_ff >> t_in);
      sq_n_ff[0] <= 64'(q_b_ff[0]) * 64'(q_b_ff[0]) + 64'(q_b_ff[1]) * 64'(q_b_ff[1]) +
                    64'(q_b_ff[2]) * 64'(q_b_ff[2]);
      sq_r_ff[0] <= '0;
      sq_x_ff[0] <= c_b_ff[63] ? 64'(-c_b_ff) : 64'(c_b_ff);
      neg_c_ff <= c_b_ff[63];
   end

   // Restoring square root, one result bit per stage.
   for (genvar g = 0; g < SqStages; g++) begin : g_sqrt
      logic [63:0] bitv, trial;
      assign bitv  = 64'd1 << (62 - 2 * g);
      assign trial = sq_r_ff[g] + bitv;
      always_ff @(posedge clock) begin
         sq_x_ff[g+1] <= sq_x_ff[g];
         if (sq_n_ff[g] >= trial) begin
            sq_n_ff[g+1] <= sq_n_ff[g] - trial;
            sq_r_ff[g+1] <= (sq_r_ff[g] >> 1) + bitv;
         end else begin
            sq_n_ff[g+1] <= sq_n_ff[g];
            sq_r_ff[g+1] <= sq_r_ff[g] >> 1;
         end
      end
   end

   // Prescale both below 2^32 by common halving.
   logic [5:0]  h;
   logic [63:0] xs, ys;
   always_comb begin
      h = '0;
      for (int s = 0; s < 33; s++)
         if ((sq_x_ff[SqStages] >> s) >= 64'h1_0000_0000 ||
             (sq_r_ff[SqStages] >> s) >= 64'h1_0000_0000)
            h = 6'(s + 1);
      xs = sq_x_ff[SqStages] >> h;
      ys = sq_r_ff[SqStages] >> h;
   end

   logic signed [34:0] cx_ff [Steps+1];
   logic signed [34:0] cy_ff [Steps+1];
   logic signed [ZW-1:0] cz_ff [Steps+1];
   always_ff @(posedge clock) begin
      cx_ff[0] <= 35'(xs);
      cy_ff[0] <= 35'(ys);
      cz_ff[0] <= '0;
   end
   for (genvar g = 0; g < Steps; g++) begin : g_cordic
      localparam logic [63:0] At = atan_tab(g);
      logic signed [34:0] dx, dy;
      assign dx = cy_ff[g][34] ? -35'((-cy_ff[g]) >>> g) : 35'(cy_ff[g] >>> g);
      assign dy = cx_ff[g][34] ? -35'((-cx_ff[g]) >>> g) : 35'(cx_ff[g] >>> g);
      always_ff @(posedge clock) begin
         if (!cy_ff[g][34]) begin
            cx_ff[g+1] <= cx_ff[g] + dx;
            cy_ff[g+1] <= cy_ff[g] - dy;
            cz_ff[g+1] <= cz_ff[g] + $signed(At);
         end else begin
            cx_ff[g+1] <= cx_ff[g] - dx;
            cy_ff[g+1] <= cy_ff[g] + dy;
            cz_ff[g+1] <= cz_ff[g] - $signed(At);
         end
      end
   end

   logic [63:0] zc, ang_ff;
   assign zc = cz_ff[Steps][ZW-1] ? '0 : 64'(cz_ff[Steps]);
   always_ff @(posedge clock) begin
      if (neg_ff[NegLen-1]) ang_ff <= (zc > PiZ) ? '0 : PiZ - zc;
      else ang_ff <= zc;
   end

   // Control travels alongside; neg joins after the dot product is known.
   always_ff @(posedge clock) begin
      if (reset) val_ff <= '0;
      else val_ff <= {val_ff[Lat-2:0], in_valid};
      zero_ff <= {zero_ff[Lat-2:0], in_zero};
      neg_ff  <= {neg_ff[NegLen-2:0], neg_c_ff};
   end

   assign out_valid = val_ff[Lat-1];
   assign out_zero  = zero_ff[Lat-1];
   assign out_ang   = ang_ff;
endmodule

[sv/tmda_min.sv]
// Minimum over the six per-edge angles through a registered tree, then rounding.
// Depends on tmda_pkg.
module tmda_min #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [5:0]         in_zero,
   input  logic [63:0]        in_ang [6],
   output logic               out_valid,
   output tmda_pkg::rsp_type  out_rsp
);
   import tmda_pkg::*;

   localparam int Sh = FracZ - ANGLE_FRAC_BITS;

   logic [63:0] m1_ff [3];
   logic [63:0] m2_ff, m3_in;
   logic        dg1_ff, dg2_ff, v1_ff, v2_ff, v3_ff;
   logic [63:0] m2b_ff;
   rsp_type     rsp_ff;

   always_comb m3_in = (m2_ff < m2b_ff) ? m2_ff : m2b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      for (int i = 0; i < 3; i++)
         m1_ff[i] <= (in_ang[2*i] < in_ang[2*i+1]) ? in_ang[2*i] : in_ang[2*i+1];
      dg1_ff <= |in_zero;
      m2_ff  <= (m1_ff[0] < m1_ff[1]) ? m1_ff[0] : m1_ff[1];
      m2b_ff <= m1_ff[2];
      dg2_ff <= dg1_ff;
      rsp_ff.degenerate <= dg2_ff;
      rsp_ff.min_angle  <= dg2_ff ? '0 :
                           AngleW'((m3_in + (64'd1 << (Sh - 1))) >> Sh);
   end

   assign out_valid = v3_ff;
   assign out_rsp   = rsp_ff;
endmodule

[sv/tet_min_dihedral_angle_core.sv]
// Top level of the tetrahedron minimum dihedral angle core.
// Depends on tmda_pkg, tmda_normal, tmda_angle and tmda_min.
//
//   Channel  Ports                         Direction  Transfer
//   request  start, busy, req_data         in         start high while busy low
//   result   rsp_valid, rsp_data           out        rsp_valid high, one cycle
//
// One tetrahedron is taken every cycle; busy is tied low because the
// pipeline never needs to stop. The path holds 84 register stages:
// four normal stages, three stages for dot, shift and squares, a 32-stage
// square root, one prescale stage, a 40-stage CORDIC, one fold stage and a
// three-stage minimum tree. The six per-edge lanes run side by side.
// Reset clears only the valid bits. The receiver cannot stall the result.
module tet_min_dihedral_angle_core #(
   parameter int ANGLE_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tmda_pkg::req_type  req_data,
   output logic               rsp_valid,
   output tmda_pkg::rsp_type  rsp_data
);
   import tmda_pkg::*;

   // Vertices at the coordinate width of the request fields.
   logic signed [CoordW-1:0] v [4][3];
   logic                     take;

   assign busy = 1'b0;
   assign take = start & ~busy;

   always_comb begin
      v[0][0] = req_data.v0_x;
      v[0][1] = req_data.v0_y;
      v[0][2] = req_data.v0_z;
      v[1][0] = req_data.v1_x;
      v[1][1] = req_data.v1_y;
      v[1][2] = req_data.v1_z;
      v[2][0] = req_data.v2_x;
      v[2][1] = req_data.v2_y;
      v[2][2] = req_data.v2_z;
      v[3][0] = req_data.v3_x;
      v[3][1] = req_data.v3_y;
      v[3][2] = req_data.v3_z;
   end

   logic [5:0]  lane_valid, lane_zero;
   logic [63:0] lane_ang [6];

   // Six per-edge lanes work side by side on the same tetrahedron.
   for (genvar e = 0; e < 6; e++) begin : g_edge
      logic               nv, nz;
      logic signed [63:0] nc;
      logic signed [63:0] nw [3];

      tmda_normal #(.COORD_BITS(CoordW)) u_normal (
         .clock(clock), .reset(reset), .in_valid(take),
         .vi(v[EdgeTab[e][0]]), .vj(v[EdgeTab[e][1]]),
         .vk(v[EdgeTab[e][2]]), .vm(v[EdgeTab[e][3]]),
         .out_valid(nv), .out_zero(nz), .out_c(nc), .out_w(nw)
      );

      tmda_angle u_angle (
         .clock(clock), .reset(reset), .in_valid(nv), .in_zero(nz),
         .in_c(nc), .in_w(nw),
         .out_valid(lane_valid[e]), .out_zero(lane_zero[e]), .out_ang(lane_ang[e])
      );
   end

   tmda_min #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_min (
      .clock(clock), .reset(reset), .in_valid(&lane_valid),
      .in_zero(lane_zero), .in_ang(lane_ang),
      .out_valid(rsp_valid), .out_rsp(rsp_data)
   );
endmodule
